@@ rtl/core/adc_median_history_filter_unit_assert.svh @@
`ifndef ADC_MEDIAN_HISTORY_FILTER_UNIT_ASSERT_SVH
`define ADC_MEDIAN_HISTORY_FILTER_UNIT_ASSERT_SVH

// cond must hold at every clock edge out of reset
`define AMHF_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// cons must hold in the same cycle as ante
`define AMHF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define AMHF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/amhf_pkg.sv @@
package amhf_pkg;

    localparam int CHANNELS       = 8;
    localparam int HISTORY_DEPTH  = 3;

    localparam int CH_W           = 3;
    localparam int SAMPLE_W       = 15;
    localparam int MV_W           = 12;
    localparam int CH_IDX_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SLOT_W         = $clog2(HISTORY_DEPTH);
    localparam int SUM_W          = SAMPLE_W + $clog2(HISTORY_DEPTH);
    localparam int TRIM_DIV       = HISTORY_DEPTH - 2;

    localparam int MV_SCALE       = 3300;
    localparam int MV_SCALE_W     = 12;
    localparam int CODE_SPAN_LOG2 = 15;
    localparam int PROD_W         = SAMPLE_W + MV_SCALE_W;

    typedef enum logic {
        ACT_STORE = 1'b0,
        ACT_READ  = 1'b1
    } t_action;

    typedef struct packed {
        t_action             action;
        logic [CH_W-1:0]     channel;
        logic [SAMPLE_W-1:0] sample;
        logic                keep_history;
        logic                advance_set;
        logic                debounced_read;
    } t_item;

endpackage

@@ rtl/core/amhf_if.sv @@
interface amhf_item_if;
    import amhf_pkg::*;

    logic                valid;
    logic                ready;
    logic                action;
    logic [CH_W-1:0]     channel;
    logic [SAMPLE_W-1:0] sample;
    logic                keep_history;
    logic                advance_set;
    logic                debounced_read;

    modport source (
        output valid, action, channel, sample, keep_history, advance_set, debounced_read,
        input  ready
    );
    modport sink (
        input  valid, action, channel, sample, keep_history, advance_set, debounced_read,
        output ready
    );
endinterface

interface amhf_res_if;
    import amhf_pkg::*;

    logic            valid;
    logic            ready;
    logic [MV_W-1:0] millivolts;

    modport source (output valid, millivolts, input ready);
    modport sink   (input valid, millivolts, output ready);
endinterface

interface amhf_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ rtl/core/amhf_store.sv @@
`include "adc_median_history_filter_unit_assert.svh"

module amhf_store (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_item_valid,
    input  amhf_pkg::t_item          i_item,
    input  logic                     i_enabled,
    output logic                     o_item_take,
    output logic                     o_value_valid,
    output logic [amhf_pkg::SAMPLE_W-1:0] o_value,
    input  logic                     i_value_take
);
    import amhf_pkg::*;

    logic [SAMPLE_W-1:0] r_latest [CHANNELS];
    logic [SAMPLE_W-1:0] r_hist [HISTORY_DEPTH][CHANNELS];
    logic [SLOT_W-1:0]   r_slot;
    logic                r_value_valid;
    logic [SAMPLE_W-1:0] r_value;
    logic [SAMPLE_W-1:0] n_value;

    logic [CH_IDX_W-1:0] ch_idx;
    logic                ch_ok;
    logic                is_read;
    logic                do_store;
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;
    logic [SUM_W-1:0]    sum;
    logic [SUM_W-1:0]    trim_sum;
    logic [SUM_W-1:0]    trim_mean;

    assign ch_idx   = CH_IDX_W'(i_item.channel);
    assign ch_ok    = (32'(i_item.channel) < CHANNELS);
    assign is_read  = (i_item.action == ACT_READ);

    assign o_item_take = i_item_valid && (!is_read || !r_value_valid || i_value_take);
    assign do_store    = o_item_take && !is_read && i_enabled && ch_ok;

    always_comb begin
        lo  = '1;
        hi  = '0;
        sum = '0;
        for (int k = 0; k < HISTORY_DEPTH; k++) begin
            if (r_hist[k][ch_idx] < lo) lo = r_hist[k][ch_idx];
            if (r_hist[k][ch_idx] > hi) hi = r_hist[k][ch_idx];
            sum = sum + SUM_W'(r_hist[k][ch_idx]);
        end
        trim_sum = sum - SUM_W'(lo) - SUM_W'(hi);
    end

    generate
        if ((TRIM_DIV & (TRIM_DIV - 1)) == 0) begin : g_div_shift
            assign trim_mean = trim_sum >> $clog2(TRIM_DIV);
        end else begin : g_div_recip
            localparam logic [SUM_W-1:0] RECIP = SUM_W'((64'd1 << SUM_W) / TRIM_DIV);
            logic [2*SUM_W-1:0] prod;
            logic [SUM_W-1:0]   q0;
            logic [SUM_W-1:0]   rem;
            // reciprocal estimate is low by at most one
            assign prod      = trim_sum * RECIP;
            assign q0        = prod[2*SUM_W-1:SUM_W];
            assign rem       = trim_sum - SUM_W'(q0 * TRIM_DIV);
            assign trim_mean = (rem >= SUM_W'(TRIM_DIV)) ? q0 + 1'b1 : q0;
        end
    endgenerate

    always_comb begin
        if (!ch_ok) begin
            n_value = '0;
        end else if (i_item.debounced_read) begin
            n_value = SAMPLE_W'(trim_mean);
        end else begin
            n_value = r_latest[ch_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot        <= '0;
            r_value_valid <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_latest[c] <= '0;
                for (int k = 0; k < HISTORY_DEPTH; k++) begin
                    r_hist[k][c] <= '0;
                end
            end
        end else begin
            if (do_store) begin
                r_latest[ch_idx] <= i_item.sample;
                if (i_item.keep_history) begin
                    r_hist[r_slot][ch_idx] <= i_item.sample;
                end
                if (i_item.advance_set) begin
                    r_slot <= (r_slot == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : r_slot + 1'b1;
                end
            end
            if (o_item_take && is_read) begin
                r_value_valid <= 1'b1;
            end else if (i_value_take) begin
                r_value_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_item_take && is_read) begin
            r_value <= n_value;
        end
    end

    assign o_value_valid = r_value_valid;
    assign o_value       = r_value;

    `AMHF_ASSERT_ALWAYS(a_slot_range, i_clk, i_rst_n, r_slot <= SLOT_W'(HISTORY_DEPTH - 1), "history slot out of range")
    `AMHF_ASSERT_NEXT(a_value_hold, i_clk, i_rst_n, r_value_valid && !i_value_take, r_value_valid && $stable(r_value), "pending value lost")
    `AMHF_ASSERT_NEXT(a_disabled_store, i_clk, i_rst_n, o_item_take && !is_read && !i_enabled, $stable(r_slot), "slot moved while disabled")
    `AMHF_ASSERT_NEXT(a_read_fills, i_clk, i_rst_n, o_item_take && is_read, r_value_valid, "read transaction dropped")

endmodule

@@ rtl/core/amhf_scale.sv @@
module amhf_scale (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_value_valid,
    input  logic [amhf_pkg::SAMPLE_W-1:0] i_value,
    output logic                          o_value_take,
    output logic                          o_valid,
    output logic [amhf_pkg::MV_W-1:0]     o_millivolts,
    input  logic                          i_ready
);
    import amhf_pkg::*;

    logic              r_valid;
    logic [MV_W-1:0]   r_mv;
    logic [MV_W-1:0]   n_mv;
    logic [PROD_W-1:0] product;

    assign o_value_take = i_value_valid && (!r_valid || i_ready);

    // value * 3300 / 32768
    assign product = PROD_W'(i_value) * PROD_W'(MV_SCALE);
    assign n_mv    = product[CODE_SPAN_LOG2 +: MV_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_value_take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_value_take) begin
            r_mv <= n_mv;
        end
    end

    assign o_valid      = r_valid;
    assign o_millivolts = r_mv;

endmodule

@@ rtl/core/adc_median_history_filter_unit.sv @@
// Path: a read result passes the input register, the value register and the
// output register in order; back-pressure can hold it in any of them.
// Throughput: one transaction per cycle unless the result output stalls;
// stores yield no result. Reset: synchronous, clears enable, history slot,
// latest and history values to zero; no clearing pass.
module adc_median_history_filter_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    amhf_cfg_if.sink     i_cfg,
    amhf_item_if.sink    i_item,
    amhf_res_if.source   o_result
);
    import amhf_pkg::*;

    logic                r_enabled;
    logic                r_in_valid;
    t_item               r_in;
    logic                in_take;
    logic                value_valid;
    logic [SAMPLE_W-1:0] value;
    logic                value_take;

    assign i_cfg.ready  = 1'b1;
    assign i_item.ready = !r_in_valid || in_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled  <= 1'b0;
            r_in_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_enabled <= i_cfg.data;
            end
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in.action         <= t_action'(i_item.action);
            r_in.channel        <= i_item.channel;
            r_in.sample         <= i_item.sample;
            r_in.keep_history   <= i_item.keep_history;
            r_in.advance_set    <= i_item.advance_set;
            r_in.debounced_read <= i_item.debounced_read;
        end
    end

    amhf_store u_store (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (r_in_valid),
        .i_item        (r_in),
        .i_enabled     (r_enabled),
        .o_item_take   (in_take),
        .o_value_valid (value_valid),
        .o_value       (value),
        .i_value_take  (value_take)
    );

    amhf_scale u_scale (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_value_valid (value_valid),
        .i_value       (value),
        .o_value_take  (value_take),
        .o_valid       (o_result.valid),
        .o_millivolts  (o_result.millivolts),
        .i_ready       (o_result.ready)
    );

endmodule
